@@ src/bpi_pkg.sv @@
// ----------------------------------------------------------------------------
// Bigram position index package
// Shared widths, payload structs, opcodes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package bpi_pkg;

   localparam int ADDR_W = 16;
   localparam int KEY_W  = 16;
   localparam int CNT_W  = 16;
   localparam int LEN_W  = ADDR_W + 1;
   localparam int MAXP_W = 17;
   localparam int BUF_W  = 9;

   localparam logic [MAXP_W-1:0] MAXP_RESET = 17'h10000;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_NOT_BUILT = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_BUILD = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [7:0]        data_byte;
      logic              byte_excluded;
      logic [KEY_W-1:0]  query_key;
      logic [CNT_W-1:0]  query_slot;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0]  key_count;
      logic              positions_kept;
      logic [ADDR_W-1:0] position;
      logic              position_valid;
      logic [1:0]        status;
   } rsp_type;

   typedef enum logic [10:0] {
      S_IDLE = 11'b000_0000_0001,
      S_CLR  = 11'b000_0000_0010,
      S_PA   = 11'b000_0000_0100,
      S_PB   = 11'b000_0000_1000,
      S_PC   = 11'b000_0001_0000,
      S_PD   = 11'b000_0010_0000,
      S_XA   = 11'b000_0100_0000,
      S_XB   = 11'b000_1000_0000,
      S_QA   = 11'b001_0000_0000,
      S_QB   = 11'b010_0000_0000,
      S_QC   = 11'b100_0000_0000
   } state_type;

   function automatic logic kept_fn(input logic [CNT_W-1:0] cnt,
                                    input logic [MAXP_W-1:0] maxp);
      return (cnt != '0) && ({1'b0, cnt} <= maxp);
   endfunction

endpackage

@@ src/bigram_position_index.sv @@
// ----------------------------------------------------------------------------
// Bigram position index
// Byte buffer loader, bigram index builder and position query engine.
// ----------------------------------------------------------------------------
// A load transfer is answered directly from the idle state; a query steps
// through states QA, QB and QC. A build is handled by one small sequencer over
// simple dual-port memories: a count clear, a count pass over the pairs, a
// prefix pass over all keys and a scatter pass over the pairs. No request is
// taken while an item is in progress. Memory contents are not cleared at
// reset; the counts are cleared at the start of each build.
module bigram_position_index import bpi_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [MAXP_W-1:0] csr_wdata
);

   state_type         state_ff, state_in;
   logic              pass_ff, pass_in;
   logic [ADDR_W-1:0] j_ff, j_in;
   logic [KEY_W-1:0]  k_ff, k_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              built_ff, built_in;
   logic              ovf_ff, ovf_in;
   logic [MAXP_W-1:0] maxp_ff, maxp_in;
   logic [CNT_W-1:0]  base_ff, base_in;
   logic [BUF_W-1:0]  cur_ff, cur_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic              pair_ok_ff, pair_ok_in;
   logic [KEY_W-1:0]  qkey_ff, qkey_in;
   logic [CNT_W-1:0]  qslot_ff, qslot_in;
   logic [CNT_W-1:0]  qcnt_ff, qcnt_in;
   logic              qkept_ff, qkept_in;
   logic              qpv_ff, qpv_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              req_take;
   logic              produce;
   rsp_type           rsp_next;
   logic [KEY_W-1:0]  pair_key;
   logic              pair_ok;
   logic              last_k;
   logic              long_buf;
   logic [ADDR_W-1:0] start_j;

   logic              buf_we;
   logic [ADDR_W-1:0] buf_waddr, buf_raddr;
   logic [BUF_W-1:0]  buf_wdata, buf_rdata;
   logic              cnt_we;
   logic [KEY_W-1:0]  cnt_waddr, cnt_raddr;
   logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;
   logic              off_we;
   logic [KEY_W-1:0]  off_waddr, off_raddr;
   logic [CNT_W-1:0]  off_wdata, off_rdata;
   logic              fill_we;
   logic [KEY_W-1:0]  fill_waddr, fill_raddr;
   logic [CNT_W-1:0]  fill_wdata, fill_rdata;
   logic              pos_we;
   logic [ADDR_W-1:0] pos_waddr, pos_raddr;
   logic [ADDR_W-1:0] pos_wdata, pos_rdata;

   bpi_ram #(.ADDR_W(ADDR_W), .DATA_W(BUF_W)) u_buf (
      .clock(clock), .we(buf_we), .waddr(buf_waddr), .wdata(buf_wdata),
      .raddr(buf_raddr), .rdata(buf_rdata));
   bpi_ram #(.ADDR_W(KEY_W), .DATA_W(CNT_W)) u_cnt (
      .clock(clock), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
      .raddr(cnt_raddr), .rdata(cnt_rdata));
   bpi_ram #(.ADDR_W(KEY_W), .DATA_W(CNT_W)) u_off (
      .clock(clock), .we(off_we), .waddr(off_waddr), .wdata(off_wdata),
      .raddr(off_raddr), .rdata(off_rdata));
   bpi_ram #(.ADDR_W(KEY_W), .DATA_W(CNT_W)) u_fill (
      .clock(clock), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
      .raddr(fill_raddr), .rdata(fill_rdata));
   bpi_ram #(.ADDR_W(ADDR_W), .DATA_W(ADDR_W)) u_pos (
      .clock(clock), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
      .raddr(pos_raddr), .rdata(pos_rdata));

   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The earlier byte of a pair arrives from the buffer after the later one.
   assign pair_key = {cur_ff[7:0], buf_rdata[7:0]};
   assign pair_ok  = !cur_ff[8] && !buf_rdata[8];
   assign last_k   = (k_ff == '1);
   assign long_buf = (len_ff > LEN_W'(1));
   assign start_j  = ADDR_W'(len_ff - LEN_W'(1));

   always_comb begin
      state_in   = state_ff;
      pass_in    = pass_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      len_in     = len_ff;
      built_in   = built_ff;
      ovf_in     = ovf_ff;
      maxp_in    = csr_we ? csr_wdata : maxp_ff;
      base_in    = base_ff;
      cur_in     = cur_ff;
      key_in     = key_ff;
      pair_ok_in = pair_ok_ff;
      qkey_in    = qkey_ff;
      qslot_in   = qslot_ff;
      qcnt_in    = qcnt_ff;
      qkept_in   = qkept_ff;
      qpv_in     = qpv_ff;
      produce    = 1'b0;
      rsp_next   = '0;

      buf_we     = 1'b0;
      buf_waddr  = len_ff[ADDR_W-1:0];
      buf_wdata  = {req_data.byte_excluded, req_data.data_byte};
      buf_raddr  = j_ff;
      cnt_we     = 1'b0;
      cnt_waddr  = k_ff;
      cnt_wdata  = '0;
      cnt_raddr  = k_ff;
      off_we     = 1'b0;
      off_waddr  = k_ff;
      off_wdata  = base_ff;
      off_raddr  = qkey_ff;
      fill_we    = 1'b0;
      fill_waddr = k_ff;
      fill_wdata = '0;
      fill_raddr = pair_key;
      pos_we     = 1'b0;
      pos_waddr  = off_rdata + fill_rdata;
      pos_wdata  = j_ff - ADDR_W'(1);
      pos_raddr  = off_rdata + qslot_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               case (req_data.op)
                  OP_LOAD: begin
                     produce = 1'b1;
                     if (len_ff[LEN_W-1]) begin
                        ovf_in          = 1'b1;
                        rsp_next.status = ST_OVERFLOW;
                     end else begin
                        buf_we = 1'b1;
                        len_in = len_ff + LEN_W'(1);
                     end
                  end
                  OP_BUILD: begin
                     k_in     = '0;
                     base_in  = '0;
                     state_in = S_CLR;
                  end
                  OP_QUERY: begin
                     if (!built_ff) begin
                        produce         = 1'b1;
                        rsp_next.status = ST_NOT_BUILT;
                     end else begin
                        qkey_in  = req_data.query_key;
                        qslot_in = req_data.query_slot;
                        state_in = S_QA;
                     end
                  end
                  default: begin
                     produce = 1'b1;
                  end
               endcase
            end
         end
         S_CLR: begin
            cnt_we = 1'b1;
            k_in   = k_ff + KEY_W'(1);
            if (last_k) begin
               if (long_buf) begin
                  j_in     = start_j;
                  pass_in  = 1'b0;
                  state_in = S_PA;
               end else begin
                  state_in = S_XA;
               end
            end
         end
         S_PA: begin
            state_in = S_PB;
         end
         S_PB: begin
            cur_in    = buf_rdata;
            buf_raddr = j_ff - ADDR_W'(1);
            state_in  = S_PC;
         end
         S_PC: begin
            key_in     = pair_key;
            pair_ok_in = pair_ok;
            cnt_raddr  = pair_key;
            off_raddr  = pair_key;
            state_in   = S_PD;
         end
         S_PD: begin
            if (!pass_ff) begin
               cnt_we    = pair_ok_ff;
               cnt_waddr = key_ff;
               cnt_wdata = cnt_rdata + CNT_W'(1);
            end else if (pair_ok_ff && kept_fn(cnt_rdata, maxp_ff)) begin
               // Slots fill upward while positions run downward.
               pos_we     = 1'b1;
               fill_we    = 1'b1;
               fill_waddr = key_ff;
               fill_wdata = fill_rdata + CNT_W'(1);
            end
            if (j_ff == ADDR_W'(1)) begin
               if (!pass_ff) begin
                  k_in     = '0;
                  state_in = S_XA;
               end else begin
                  built_in        = 1'b1;
                  produce         = 1'b1;
                  rsp_next.status = ovf_ff ? ST_OVERFLOW : ST_OK;
                  state_in        = S_IDLE;
               end
            end else begin
               j_in     = j_ff - ADDR_W'(1);
               state_in = S_PA;
            end
         end
         S_XA: begin
            state_in = S_XB;
         end
         S_XB: begin
            off_we  = 1'b1;
            fill_we = 1'b1;
            if (kept_fn(cnt_rdata, maxp_ff)) begin
               base_in = base_ff + cnt_rdata;
            end
            k_in = k_ff + KEY_W'(1);
            if (last_k) begin
               if (long_buf) begin
                  j_in     = start_j;
                  pass_in  = 1'b1;
                  state_in = S_PA;
               end else begin
                  built_in        = 1'b1;
                  produce         = 1'b1;
                  rsp_next.status = ovf_ff ? ST_OVERFLOW : ST_OK;
                  state_in        = S_IDLE;
               end
            end else begin
               state_in = S_XA;
            end
         end
         S_QA: begin
            cnt_raddr = qkey_ff;
            state_in  = S_QB;
         end
         S_QB: begin
            qcnt_in  = cnt_rdata;
            qkept_in = kept_fn(cnt_rdata, maxp_ff);
            qpv_in   = kept_fn(cnt_rdata, maxp_ff) && (qslot_ff < cnt_rdata);
            state_in = S_QC;
         end
         S_QC: begin
            produce                 = 1'b1;
            rsp_next.key_count      = qcnt_ff;
            rsp_next.positions_kept = qkept_ff;
            rsp_next.position_valid = qpv_ff;
            rsp_next.position       = qpv_ff ? pos_rdata : '0;
            rsp_next.status         = ST_OK;
            state_in                = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = produce || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = produce ? rsp_next : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         built_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         maxp_ff      <= MAXP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         built_ff     <= built_in;
         ovf_ff       <= ovf_in;
         maxp_ff      <= maxp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pass_ff     <= pass_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      base_ff     <= base_in;
      cur_ff      <= cur_in;
      key_ff      <= key_in;
      pair_ok_ff  <= pair_ok_in;
      qkey_ff     <= qkey_in;
      qslot_ff    <= qslot_in;
      qcnt_ff     <= qcnt_in;
      qkept_ff    <= qkept_in;
      qpv_ff      <= qpv_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state is not one-hot");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(2**ADDR_W))
      else $error("loaded length exceeds buffer depth");

   a_pv_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.position_valid || rsp_data_ff.positions_kept))
      else $error("position valid without kept positions");

   a_unbuilt_query: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == ST_NOT_BUILT) |->
         (rsp_data_ff.key_count == '0 && !rsp_data_ff.positions_kept))
      else $error("query before build carries data");

   a_build_end: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) != S_IDLE && state_ff == S_IDLE) |-> rsp_valid_ff)
      else $error("item finished without a response");

endmodule

@@ src/bpi_ram.sv @@
// ----------------------------------------------------------------------------
// Bigram position index RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bpi_ram #(
   parameter int ADDR_W = 16,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
